FILE: hdl/wvm_pkg.sv
// shared types, constants and codes of the wavetable voice mixer
package wvm_pkg;

    localparam int VOICE_COUNT_DEF = 6;
    localparam int TABLE_DEPTH_DEF = 2048;

    localparam logic [24:0] LEVEL_ONE = 25'h1000000;
    localparam logic [13:0] AGE_MAX   = 14'h3fff;

    // accumulator, scaled mix and divide widths (sized for up to 16 voices)
    localparam int SUM_W   = 35;
    localparam int SCALE_W = 53;
    // dividend clamp: anything above it saturates for every voice count
    localparam int DIVX_W  = 28;
    localparam int QUOT_W  = DIVX_W + 1;

    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_REL_AFT = 3'd4;
    localparam logic [2:0] REG_VOLUME  = 3'd5;

    localparam logic [24:0] ATTACK_RST  = 25'd349;
    localparam logic [24:0] DECAY_RST   = 25'd349;
    localparam logic [24:0] SUSTAIN_RST = 25'd8388608;
    localparam logic [24:0] RELEASE_RST = 25'd87;
    localparam logic [13:0] REL_AFT_RST = 14'd2400;
    localparam logic [16:0] VOLUME_RST  = 17'd65536;

    typedef enum logic [2:0] {
        STG_IDLE,
        STG_ATTACK,
        STG_DECAY,
        STG_SUSTAIN,
        STG_RELEASE
    } stage_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_MUL,
        ST_ACC,
        ST_NEXT,
        ST_SCALE,
        ST_DIVINIT,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [24:0] attack_step;
        logic [24:0] decay_step;
        logic [24:0] sustain_level;
        logic [24:0] release_step;
        logic [13:0] release_after;
        logic [16:0] volume;
    } cfg_t;

    typedef struct packed {
        logic pluck;
        logic sum_clr;
        logic pos_load;
        logic env_step;
        logic rd_hi;
        logic d0_cap;
        logic interp_load;
        logic mul_load;
        logic acc;
        logic age_inc;
        logic scale_load;
        logic div_init;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_sts_t;

endpackage

FILE: hdl/wvm_rom.sv
// four-harmonic wavetable rom with registered read
module wvm_rom
    import wvm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                     aclk,
    input  logic [ADDR_W-1:0]        addr,
    output logic signed [15:0]       rdata
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sine of a turn fraction in q32, result q30, degree 13 series on first quadrant
    function automatic longint sine_q30(input logic [31:0] a);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        r = {34'd0, a[29:0]};
        if (a[30]) begin
            r = 64'h40000000 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        return a[31] ? -sum : sum;
    endfunction

    function automatic longint harmonic(input longint k, input longint i);
        logic [63:0] m;
        logic [63:0] ang;
        m   = 64'((k * i) % TABLE_DEPTH);
        ang = (m << 32) / TABLE_DEPTH;
        return sine_q30(ang[31:0]);
    endfunction

    function automatic logic signed [15:0] rom_entry(input longint i);
        longint acc;
        longint mag;
        longint v;
        acc = 100 * harmonic(1, i) + 45 * harmonic(2, i)
            + 20 * harmonic(3, i) + 10 * harmonic(4, i);
        mag = (acc < 0) ? -acc : acc;
        v   = (mag + 3276800) / 6553600;
        if (acc < 0) begin
            v = -v;
        end
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    logic signed [15:0] rom_data [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
        assign rom_data[g] = rom_entry(longint'(g));
    end

    always_ff @(posedge aclk) begin
        rdata <= rom_data[addr];
    end

endmodule

FILE: hdl/wvm_dp.sv
// voice state, shared interpolate-envelope-multiply unit, mixer and output register
module wvm_dp
    import wvm_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VSEL_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    input  logic [VSEL_W-1:0] vsel,
    input  logic [2:0]        voice_index,
    input  logic [30:0]       phase_step,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [23:0]       m_tdata,
    output dp_sts_t           sts
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int POS_W  = 32 + ADDR_W;
    localparam int PROD_W = DIVX_W + 33;

    // ceil(2^32 / VOICE_COUNT), exact floor division for dividends below 2^DIVX_W
    localparam longint      RECIP_L = ((longint'(1) << 32) + longint'(VOICE_COUNT) - 1)
                                      / longint'(VOICE_COUNT);
    localparam logic [32:0] RECIP   = 33'(RECIP_L);

    logic [31:0] phase_reg [VOICE_COUNT];
    logic [31:0] step_reg  [VOICE_COUNT];
    logic [24:0] level_reg [VOICE_COUNT];
    stage_t      stage_reg [VOICE_COUNT];
    logic [13:0] age_reg   [VOICE_COUNT];

    logic [ADDR_W-1:0]         i0_reg, i1_reg, i0_next;
    logic [15:0]               frac_reg;
    logic signed [15:0]        d0_reg, rom_q;
    logic signed [33:0]        interp_reg, interp_next;
    logic signed [59:0]        prod_reg, prod_next, contrib;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SCALE_W-1:0] scaled_reg, scaled_next, magn;
    logic                      neg_reg;
    logic [DIVX_W-1:0]         divx_reg, divx_next;
    logic [PROD_W-1:0]         recip_prod;
    logic [QUOT_W-1:0]         quot_reg;
    logic                      m_tvalid_reg;
    logic [23:0]               m_tdata_reg, out_next;
    logic [POS_W-1:0]          pos;
    logic [ADDR_W-1:0]         rom_addr;
    logic [VSEL_W-1:0]         pidx;
    logic                      pidx_ok;

    logic [24:0]        sus;
    stage_t             stg_cur, stg_next;
    logic signed [26:0] lvl_t;
    logic [24:0]        lvl_next;

    assign pidx    = VSEL_W'(voice_index);
    assign pidx_ok = ({2'b00, voice_index} < 5'(VOICE_COUNT));

    // table position and interpolation fraction
    assign pos     = POS_W'(phase_reg[vsel]) * POS_W'(TABLE_DEPTH);
    assign i0_next = pos[POS_W-1:32];

    assign rom_addr = cmd.rd_hi ? i1_reg : i0_reg;

    wvm_rom #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_rom (
        .aclk  (aclk),
        .addr  (rom_addr),
        .rdata (rom_q)
    );

    // rom[i0]*(1-f) + rom[i1]*f written as rom[i0] + (rom[i1]-rom[i0])*f
    always_comb begin
        logic signed [16:0] diff;
        diff        = 17'(rom_q) - 17'(d0_reg);
        interp_next = {{2{d0_reg[15]}}, d0_reg, 16'd0}
                    + 34'(diff) * $signed({18'd0, frac_reg});
    end

    assign prod_next = 60'(interp_reg) * 60'($signed({1'b0, level_reg[vsel]}));
    assign contrib   = (prod_reg + (prod_reg[59] ? 60'sd1073741823 : 60'sd0)) >>> 30;

    assign scaled_next = SCALE_W'(sum_reg) * SCALE_W'($signed({1'b0, cfg.volume}));
    assign magn        = scaled_reg[SCALE_W-1] ? -scaled_reg : scaled_reg;

    // magnitude over 2^17, clamped: past the clamp the quotient saturates either way
    assign divx_next  = (|magn[SCALE_W-1:17+DIVX_W]) ? '1 : magn[17+DIVX_W-1:17];
    assign recip_prod = PROD_W'(divx_reg) * PROD_W'(RECIP);

    always_comb begin
        if (!neg_reg) begin
            out_next = (quot_reg > QUOT_W'(8388607)) ? 24'h7fffff : quot_reg[23:0];
        end else begin
            out_next = (quot_reg > QUOT_W'(8388608)) ? 24'h800000 : 24'(-quot_reg);
        end
    end

    // envelope of the selected voice
    always_comb begin
        sus      = (cfg.sustain_level > LEVEL_ONE) ? LEVEL_ONE : cfg.sustain_level;
        stg_cur  = (age_reg[vsel] > cfg.release_after) ? STG_RELEASE : stage_reg[vsel];
        stg_next = stg_cur;
        lvl_next = level_reg[vsel];
        lvl_t    = 27'sd0;
        case (stg_cur)
            STG_ATTACK: begin
                lvl_t = $signed({2'b00, level_reg[vsel]}) + $signed({2'b00, cfg.attack_step});
                if (lvl_t >= $signed({2'b00, LEVEL_ONE})) begin
                    lvl_next = LEVEL_ONE;
                    stg_next = STG_DECAY;
                end else begin
                    lvl_next = lvl_t[24:0];
                end
            end
            STG_DECAY: begin
                lvl_t = $signed({2'b00, level_reg[vsel]}) - $signed({2'b00, cfg.decay_step});
                if (lvl_t <= $signed({2'b00, sus})) begin
                    lvl_next = sus;
                    stg_next = STG_SUSTAIN;
                end else begin
                    lvl_next = lvl_t[24:0];
                end
            end
            STG_RELEASE: begin
                lvl_t = $signed({2'b00, level_reg[vsel]}) - $signed({2'b00, cfg.release_step});
                if (lvl_t <= 27'sd0) begin
                    lvl_next = 25'd0;
                    stg_next = STG_IDLE;
                end else begin
                    lvl_next = lvl_t[24:0];
                end
            end
            default: begin
                lvl_next = level_reg[vsel];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                phase_reg[v] <= '0;
                step_reg[v]  <= '0;
                level_reg[v] <= '0;
                stage_reg[v] <= STG_IDLE;
                age_reg[v]   <= AGE_MAX;
            end
        end else begin
            if (cmd.pluck && pidx_ok) begin
                stage_reg[pidx] <= STG_ATTACK;
                age_reg[pidx]   <= '0;
                step_reg[pidx]  <= {1'b0, phase_step};
            end
            if (cmd.env_step) begin
                phase_reg[vsel] <= phase_reg[vsel] + step_reg[vsel];
                level_reg[vsel] <= lvl_next;
                stage_reg[vsel] <= stg_next;
            end
            if (cmd.age_inc && (age_reg[vsel] != AGE_MAX)) begin
                age_reg[vsel] <= age_reg[vsel] + 14'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pos_load) begin
            i0_reg   <= i0_next;
            i1_reg   <= (i0_next == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : i0_next + 1'b1;
            frac_reg <= pos[31:16];
        end
        if (cmd.d0_cap) begin
            d0_reg <= rom_q;
        end
        if (cmd.interp_load) begin
            interp_reg <= interp_next;
        end
        if (cmd.mul_load) begin
            prod_reg <= prod_next;
        end
        if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg <= sum_reg + SUM_W'(contrib);
        end
        if (cmd.scale_load) begin
            scaled_reg <= scaled_next;
        end
        if (cmd.div_init) begin
            neg_reg  <= scaled_reg[SCALE_W-1];
            divx_reg <= divx_next;
        end
        if (cmd.div_step) begin
            quot_reg <= recip_prod[PROD_W-1:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= out_next;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

endmodule

FILE: hdl/wvm_ctrl.sv
// sequencer: walks the voices through the shared unit, then scales and divides
module wvm_ctrl
    import wvm_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int VSEL_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              mode,
    input  logic [5:0]        active_mask,
    input  dp_sts_t           sts,
    output logic              s_tready,
    output dp_cmd_t           cmd,
    output logic [VSEL_W-1:0] vsel
);

    ctrl_state_t          state_reg, state_next;
    logic [VSEL_W-1:0]    vcnt_reg, vcnt_next;
    logic [5:0]           mask_reg, mask_next;
    logic [15:0]          mask_ext;
    logic                 last_voice;

    assign mask_ext   = {10'd0, mask_reg};
    assign last_voice = (vcnt_reg == VSEL_W'(VOICE_COUNT - 1));
    assign vsel       = vcnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vcnt_reg  <= '0;
            mask_reg  <= '0;
        end else begin
            state_reg <= state_next;
            vcnt_reg  <= vcnt_next;
            mask_reg  <= mask_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        vcnt_next  = vcnt_reg;
        mask_next  = mask_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (mode) begin
                        cmd.pluck = 1'b1;
                    end else begin
                        cmd.sum_clr = 1'b1;
                        mask_next   = active_mask;
                        vcnt_next   = '0;
                        state_next  = ST_POS;
                    end
                end
            end
            ST_POS: begin
                if (mask_ext[vcnt_reg]) begin
                    cmd.pos_load = 1'b1;
                    state_next   = ST_RD0;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_RD0: begin
                cmd.env_step = 1'b1;
                state_next   = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_hi  = 1'b1;
                cmd.d0_cap = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.interp_load = 1'b1;
                state_next      = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                // every voice ages, sounding or not
                cmd.age_inc = 1'b1;
                if (last_voice) begin
                    state_next = ST_SCALE;
                end else begin
                    vcnt_next  = vcnt_reg + 1'b1;
                    state_next = ST_POS;
                end
            end
            ST_SCALE: begin
                cmd.scale_load = 1'b1;
                state_next     = ST_DIVINIT;
            end
            ST_DIVINIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/wavetable_voice_mixer_adsr.sv
// Wavetable voice mixer with ADSR envelopes, top level.
// Input stream (s_*): s_tuser[0] is the kind, 0 tick and 1 pluck. s_tdata carries
// voice_index, phase_step and active_mask. A pluck restarts the attack of one voice
// and gives no result. A tick advances the voices in active_mask,
// ages all voices and produces one mixed 24-bit sample on m_tdata.
// A tick walks the voices one at a time through a shared interpolate and
// envelope-multiply unit (a silent voice is only aged), then scales the mix by
// the volume, divides it by the voice count (clamp, then reciprocal multiply)
// and loads the output register. The input is not ready while a tick is in
// work and is ready again in the cycle that m_tvalid rises.
// The output register holds a finished sample while m_tready is low; the block still
// takes plucks then, but a following tick waits at its end until the register frees.
// Registers must be written over the APB port while idle; the block does not enforce it.
// Synchronous active-low reset: all voices idle, level and phase zero, age at its
// maximum, registers at their defaults, output empty.
module wavetable_voice_mixer_adsr
    import wvm_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // voice_index[2:0], phase_step[33:3], active_mask[39:34]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mixed_sample[23:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VSEL_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    cfg_t              cfg_reg;
    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [VSEL_W-1:0] vsel;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_step   <= ATTACK_RST;
            cfg_reg.decay_step    <= DECAY_RST;
            cfg_reg.sustain_level <= SUSTAIN_RST;
            cfg_reg.release_step  <= RELEASE_RST;
            cfg_reg.release_after <= REL_AFT_RST;
            cfg_reg.volume        <= VOLUME_RST;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_ATTACK:  cfg_reg.attack_step   <= pwdata[24:0];
                REG_DECAY:   cfg_reg.decay_step    <= pwdata[24:0];
                REG_SUSTAIN: cfg_reg.sustain_level <= pwdata[24:0];
                REG_RELEASE: cfg_reg.release_step  <= pwdata[24:0];
                REG_REL_AFT: cfg_reg.release_after <= pwdata[13:0];
                REG_VOLUME:  cfg_reg.volume        <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ATTACK:  prdata = {7'd0, cfg_reg.attack_step};
            REG_DECAY:   prdata = {7'd0, cfg_reg.decay_step};
            REG_SUSTAIN: prdata = {7'd0, cfg_reg.sustain_level};
            REG_RELEASE: prdata = {7'd0, cfg_reg.release_step};
            REG_REL_AFT: prdata = {18'd0, cfg_reg.release_after};
            REG_VOLUME:  prdata = {15'd0, cfg_reg.volume};
            default:     prdata = '0;
        endcase
    end

    wvm_ctrl #(
        .VOICE_COUNT (VOICE_COUNT),
        .VSEL_W      (VSEL_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .mode        (s_tuser[0]),
        .active_mask (s_tdata[39:34]),
        .sts         (sts),
        .s_tready    (s_tready),
        .cmd         (cmd),
        .vsel        (vsel)
    );

    wvm_dp #(
        .VOICE_COUNT (VOICE_COUNT),
        .TABLE_DEPTH (TABLE_DEPTH),
        .VSEL_W      (VSEL_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .vsel        (vsel),
        .voice_index (s_tdata[2:0]),
        .phase_step  (s_tdata[33:3]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .sts         (sts)
    );

`ifndef SYNTH
    // a pluck never yields a sample
    a_pluck_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("pluck produced an output sample");

    // a tick keeps the input busy while the voices are worked through
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
        else $error("input ready right after tick acceptance");

    // the output register only fills from the end of a tick
    a_out_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |=> !m_tvalid || $past(cmd.out_load))
        else $error("output valid without a finished tick");
`endif

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the wavetable voice mixer with adsr envelopes
module tb_top;
    import wvm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVOICE = 6;
    localparam int NTAB = 2048;
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_PLUCK = 1'b1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // voice_index[2:0], phase_step[33:3], active_mask[39:34]
    logic [0:0]  s_tuser = '0;   // mode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // mixed_sample[23:0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wavetable_voice_mixer_adsr DUT (.*);

    always #5 aclk = ~aclk;

    // mixer model state
    shortint     wave_rom [NTAB];
    logic [31:0] osc_phase [NVOICE];
    logic [31:0] osc_step [NVOICE];
    logic [24:0] env_level [NVOICE];
    stage_t      env_stage [NVOICE];
    logic [13:0] note_age [NVOICE];
    cfg_t        regs;

    logic [23:0] sample_q [$];
    int          errors = 0;
    bit          quiet = 0;
    bit          hold_req = 0;

    typedef struct packed {
        logic        mode;
        logic [2:0]  voice;
        logic [30:0] step;
        logic [5:0]  mask;
        logic        known;
        logic [23:0] sample;
    } stim_row_t;

    stim_row_t dir_tab [20] = '{
        '{MODE_TICK,  3'd0, 31'd0,          6'h3f, 1'b1, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h00, 1'b1, 24'd0},
        '{MODE_PLUCK, 3'd6, 31'h7fffffff,   6'h00, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd7, 31'h7fffffff,   6'h3f, 1'b0, 24'd0},
        '{MODE_TICK,  3'd7, 31'h7fffffff,   6'h3f, 1'b1, 24'd0},
        '{MODE_PLUCK, 3'd0, 31'h7fffffff,   6'h00, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd1, 31'd0,          6'h00, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd2, 31'd1,          6'h00, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd3, 31'h40000000,   6'h00, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd4, 31'h12345678,   6'h00, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd5, 31'h00200000,   6'h00, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h3f, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h01, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h02, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h20, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h3f, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h3f, 1'b0, 24'd0},
        '{MODE_PLUCK, 3'd0, 31'h2aaaaaaa,   6'h00, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h3f, 1'b0, 24'd0},
        '{MODE_TICK,  3'd0, 31'd0,          6'h00, 1'b1, 24'd0}
    };

    function automatic longint sine_q30(logic [31:0] a);
        longint unsigned r, x, x2, term;
        longint s;
        r = a[29:0];
        if (a[30]) r = 64'h40000000 - r;
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        s = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'(2 * n * (2 * n + 1));
            if (n % 2 == 1) s = s - longint'(term);
            else s = s + longint'(term);
        end
        return a[31] ? -s : s;
    endfunction

    function automatic longint harmonic(int k, int i);
        logic [31:0] ang;
        ang = ((k * i) % NTAB) << 21;
        return sine_q30(ang);
    endfunction

    function automatic void model_reset();
        longint acc, mag, v;
        for (int i = 0; i < NTAB; i++) begin
            acc = 100 * harmonic(1, i) + 45 * harmonic(2, i)
                + 20 * harmonic(3, i) + 10 * harmonic(4, i);
            mag = acc < 0 ? -acc : acc;
            v = (mag + 50 * 65536) / (100 * 65536);
            if (acc < 0) v = -v;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            wave_rom[i] = shortint'(v);
        end
        for (int i = 0; i < NVOICE; i++) begin
            osc_phase[i] = '0;
            osc_step[i] = '0;
            env_level[i] = '0;
            env_stage[i] = STG_IDLE;
            note_age[i] = AGE_MAX;
        end
        regs = '{ATTACK_RST, DECAY_RST, SUSTAIN_RST, RELEASE_RST, REL_AFT_RST, VOLUME_RST};
    endfunction

    function automatic void pluck_voice(logic [2:0] v, logic [30:0] step);
        if (v < NVOICE) begin
            env_stage[v] = STG_ATTACK;
            note_age[v] = '0;
            osc_step[v] = {1'b0, step};
        end
    endfunction

    function automatic longint envelope_advance(int v);
        longint lvl, sus;
        lvl = env_level[v];
        sus = regs.sustain_level > LEVEL_ONE ? longint'(LEVEL_ONE) : longint'(regs.sustain_level);
        if (note_age[v] > regs.release_after) env_stage[v] = STG_RELEASE;
        case (env_stage[v])
            STG_ATTACK: begin
                lvl += regs.attack_step;
                if (lvl >= longint'(LEVEL_ONE)) begin
                    lvl = LEVEL_ONE;
                    env_stage[v] = STG_DECAY;
                end
            end
            STG_DECAY: begin
                lvl -= regs.decay_step;
                if (lvl <= sus) begin
                    lvl = sus;
                    env_stage[v] = STG_SUSTAIN;
                end
            end
            STG_RELEASE: begin
                lvl -= regs.release_step;
                if (lvl <= 0) begin
                    lvl = 0;
                    env_stage[v] = STG_IDLE;
                end
            end
            default: ;
        endcase
        env_level[v] = lvl[24:0];
        return lvl;
    endfunction

    function automatic logic [23:0] mix_tick(logic [5:0] mask);
        longint sum, interp, frac, lvl, mixed;
        logic [10:0] i0, i1;
        sum = 0;
        for (int v = 0; v < NVOICE; v++) begin
            if (mask[v]) begin
                i0 = osc_phase[v][31:21];
                i1 = i0 + 11'd1;
                frac = osc_phase[v][20:5];
                interp = longint'(wave_rom[i0]) * (65536 - frac) + longint'(wave_rom[i1]) * frac;
                osc_phase[v] = osc_phase[v] + osc_step[v];
                lvl = envelope_advance(v);
                sum += (interp * lvl) / (longint'(1) << 30);
            end
        end
        for (int v = 0; v < NVOICE; v++)
            if (note_age[v] < AGE_MAX) note_age[v]++;
        mixed = (sum * longint'(regs.volume)) / (NVOICE * 131072);
        if (mixed > 8388607) mixed = 8388607;
        if (mixed < -8388608) mixed = -8388608;
        return mixed[23:0];
    endfunction

    task automatic send_request(logic mode, logic [2:0] v, logic [30:0] step, logic [5:0] mask,
                                logic known, logic [23:0] typed);
        logic [23:0] pred;
        s_tdata <= {mask, step, v};
        s_tuser <= mode;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_PLUCK) begin
            pluck_voice(v, step);
        end else begin
            pred = mix_tick(mask);
            sample_q.insert(sample_q.size(), known ? typed : pred);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic send_random();
        logic [2:0] v;
        logic [30:0] step;
        if ($urandom_range(0, 99) < 35) begin
            v = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
            step = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
            send_request(MODE_PLUCK, v, step, 6'($urandom), 1'b0, '0);
        end else begin
            send_request(MODE_TICK, 3'($urandom), 31'($urandom), 6'($urandom), 1'b0, '0);
        end
    endtask

    // ticks can still be in flight after the last request; wait for every sample
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_ATTACK:  regs.attack_step = val[24:0];
            REG_DECAY:   regs.decay_step = val[24:0];
            REG_SUSTAIN: regs.sustain_level = val[24:0];
            REG_RELEASE: regs.release_step = val[24:0];
            REG_REL_AFT: regs.release_after = val[13:0];
            REG_VOLUME:  regs.volume = val[16:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] att, logic [31:0] dec, logic [31:0] sus,
                            logic [31:0] rel, logic [31:0] aft, logic [31:0] vol);
        write_reg(REG_ATTACK, att);
        write_reg(REG_DECAY, dec);
        write_reg(REG_SUSTAIN, sus);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_REL_AFT, aft);
        write_reg(REG_VOLUME, vol);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall, long_hold;
        stall = 0;
        long_hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (sample_q.size() == 0) begin
                    $error("mixed_sample unexpected, actual %0d", $signed(m_tdata));
                    errors++;
                end else begin
                    logic [23:0] want;
                    want = sample_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("mixed_sample expected %0d actual %0d",
                               $signed(want), $signed(m_tdata));
                        errors++;
                    end
                end
            end
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                long_hold = 400;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5ms;
        $display("wavetable_voice_mixer_adsr regression: fail");
        $finish;
    end

    initial begin
        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_request(dir_tab[i].mode, dir_tab[i].voice, dir_tab[i].step, dir_tab[i].mask,
                         dir_tab[i].known, dir_tab[i].sample);
        repeat (200) send_random();
        drain();

        // fast envelopes so every stage is visited
        set_regs(32'h1000000, 32'h400000, 32'h800000, 32'h200000, 32'd30, 32'd65536);
        repeat (125) send_random();
        drain();
        repeat (125) send_random();
        drain();

        // low extremes, release forced immediately and never completing
        set_regs(32'd1, 32'd0, 32'h1ffffff, 32'd0, 32'd0, 32'd0);
        repeat (50) send_random();
        // pause until every sample is back
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
        repeat (50) send_random();
        drain();

        // high extremes
        set_regs(32'h1ffffff, 32'h1ffffff, 32'd0, 32'h1ffffff, 32'd16383, 32'h1ffff);
        repeat (200) send_random();
        drain();

        set_regs($urandom_range(1, 1 << 24), $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 24),
                 $urandom_range(0, 1 << 22), $urandom_range(0, 60), $urandom_range(0, 65536));
        write_reg(REG_UNUSED, 32'hffffffff);
        hold_req = 1;
        repeat (200) send_random();
        quiet = 1;
        repeat (80) send_random();
        drain();

        if (errors == 0)
            $display("wavetable_voice_mixer_adsr regression: pass");
        else
            $display("wavetable_voice_mixer_adsr regression: fail");
        $finish;
    end

endmodule
